### hw/rtl/sbig_pkg.sv
// Shared types, codes and helpers of the shuffled batch index generator.
// No dependencies.
`timescale 1ns / 1ps
package sbig_pkg;

    localparam int DEF_MAX_ROWS  = 1024;
    localparam int DEF_MAX_BATCH = 64;

    localparam logic [31:0] ZERO_STATE_START = 32'd2463534242;

    // input function codes
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_NEXT  = 1'b1;

    // result kinds
    localparam logic [1:0] KIND_ROW       = 2'd0;
    localparam logic [1:0] KIND_EXHAUSTED = 2'd1;
    localparam logic [1:0] KIND_DONE      = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_ROW_COUNT  = 2'd0;
    localparam logic [1:0] CFG_BATCH_SIZE = 2'd1;
    localparam logic [1:0] CFG_SHUFFLE_EN = 2'd2;

    typedef struct packed {
        logic        func;
        logic [31:0] seed;
    } sbig_in_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  row_index;
        logic [10:0] batch_count;
        logic        last;
    } sbig_out_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FILL,
        ST_DRAW,
        ST_MOD,
        ST_READ,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_CNT_START,
        ST_CNT_WAIT,
        ST_DONE,
        ST_EXHAUST,
        ST_EMIT
    } sbig_state_t;

    // one xorshift32 step; a zero state starts from a fixed constant
    function automatic logic [31:0] xorshift32(input logic [31:0] s);
        logic [31:0] x;
        x = (s == 32'd0) ? ZERO_STATE_START : s;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

endpackage

### hw/rtl/sbig_if.sv
// Valid/ready channel interfaces for the input and result items.
// Depends on sbig_pkg.
`timescale 1ns / 1ps
interface sbig_in_if;
    logic               valid;
    logic               ready;
    sbig_pkg::sbig_in_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sbig_out_if;
    logic                valid;
    logic                ready;
    sbig_pkg::sbig_out_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/sbig_divider.sv
// Serial restoring divider, one quotient bit per cycle.
// Does not depend on sbig_pkg; no shared types used.
`timescale 1ns / 1ps
module sbig_divider (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [11:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [11:0] remainder
);
    logic [31:0] quo_reg, quo_next;
    logic [11:0] rem_reg, rem_next;
    logic [11:0] div_reg, div_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [12:0] trial;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[31]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = 12'd0;
            div_next  = divisor;
            cnt_next  = 6'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = 12'(trial - {1'b0, div_reg});
                quo_next = {quo_reg[30:0], 1'b1};
            end
            else
            begin
                rem_next = trial[11:0];
                quo_next = {quo_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;
endmodule

### hw/rtl/sbig_table.sv
// Permutation table: one write port, two read ports with enabled registered data.
// Standalone memory; no package use.
`timescale 1ns / 1ps
module sbig_table #(
    parameter int MAX_ROWS = 1024,
    parameter int AW       = $clog2(MAX_ROWS)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [AW-1:0] wdata,
    input  logic          ra_en,
    input  logic [AW-1:0] ra,
    output logic [AW-1:0] ra_q,
    input  logic          rb_en,
    input  logic [AW-1:0] rb,
    output logic [AW-1:0] rb_q
);
    logic [AW-1:0] mem [MAX_ROWS];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (ra_en)
            ra_q <= mem[ra];
        if (rb_en)
            rb_q <= mem[rb];
    end
endmodule

### hw/rtl/shuffled_batch_index_generator.sv
// Shuffled batch index generator: operation sequence and reset.
// After reset a clearing pass writes identity order to all entries; no item taken meanwhile.
// Next-batch item: up to batch_size (clamped) indices, one per cycle while the output is free.
// Epoch start: identity fill of rows entries, then if shuffle is on per swap a draw, serial
// modulo, read and two writes (the read waits out a pending item), then the count divide.
// Reset: generator 1, cursor 0, row_count 1024, batch_size 32, shuffle off.
`timescale 1ns / 1ps
module shuffled_batch_index_generator #(
    parameter int MAX_ROWS  = sbig_pkg::DEF_MAX_ROWS,
    parameter int MAX_BATCH = sbig_pkg::DEF_MAX_BATCH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    sbig_in_if.sink     in_ch,
    sbig_out_if.source  out_ch
);
    import sbig_pkg::*;

    localparam int AW = $clog2(MAX_ROWS);

    sbig_state_t state_reg, state_next;

    // configuration
    logic [10:0] row_count_reg;
    logic [6:0]  batch_size_reg;
    logic        shuffle_en_reg;

    // control and state
    logic [AW-1:0] clr_reg, clr_next;
    logic [10:0]   ptr_reg, ptr_next;
    logic [10:0]   i_reg, i_next;
    logic [10:0]   j_reg, j_next;
    logic [10:0]   cursor_reg, cursor_next;
    logic [10:0]   end_reg, end_next;
    logic [31:0]   gen_reg, gen_next;

    // output item register (row data lives in the table's port A register)
    logic          pend_reg, pend_next;
    logic [1:0]    kind_reg, kind_next;
    logic          last_reg, last_next;
    logic [10:0]   count_reg, count_next;

    // effective configuration
    logic [10:0] rows;
    logic [6:0]  batch;
    logic [11:0] batch_end;
    logic        out_free;
    logic        in_fire;

    // table ports
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_wdata;
    logic          ra_en, rb_en;
    logic [AW-1:0] ra, rb, ra_q, rb_q;
    logic [31:0]   ra_wide;

    // divider
    logic        div_start;
    logic [31:0] div_dividend;
    logic [11:0] div_divisor;
    logic        div_done;
    logic [31:0] div_quo;
    logic [11:0] div_rem;
    logic [31:0] x_draw;

    sbig_table #(.MAX_ROWS(MAX_ROWS), .AW(AW)) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .ra_en (ra_en),
        .ra    (ra),
        .ra_q  (ra_q),
        .rb_en (rb_en),
        .rb    (rb),
        .rb_q  (rb_q)
    );

    sbig_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // config writes; index 3 is not a register and is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg  <= 11'd1024;
            batch_size_reg <= 7'd32;
            shuffle_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ROW_COUNT:  row_count_reg  <= cfg_data;
                CFG_BATCH_SIZE: batch_size_reg <= cfg_data[6:0];
                CFG_SHUFFLE_EN: shuffle_en_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // clamp registers to the supported range
    always_comb
    begin
        if (32'(row_count_reg) > 32'(MAX_ROWS))
            rows = 11'(MAX_ROWS);
        else
            rows = row_count_reg;
        if (batch_size_reg == 7'd0)
            batch = 7'd1;
        else if (batch_size_reg > 7'(MAX_BATCH))
            batch = 7'(MAX_BATCH);
        else
            batch = batch_size_reg;
    end

    assign batch_end = {1'b0, cursor_reg} + {5'd0, batch};
    assign out_free  = !pend_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_fire   = in_ch.valid && in_ch.ready;
    assign x_draw    = xorshift32(gen_reg);

    always_comb
    begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        ptr_next     = ptr_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        cursor_next  = cursor_reg;
        end_next     = end_reg;
        gen_next     = gen_reg;
        pend_next    = pend_reg && !out_ch.ready;
        kind_next    = kind_reg;
        last_next    = last_reg;
        count_next   = count_reg;
        mem_we       = 1'b0;
        mem_waddr    = AW'(ptr_reg);
        mem_wdata    = AW'(ptr_reg);
        ra_en        = 1'b0;
        rb_en        = 1'b0;
        ra           = AW'(i_reg);
        rb           = AW'(j_reg);
        div_start    = 1'b0;
        div_dividend = x_draw;
        div_divisor  = {1'b0, i_reg} + 12'd1;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // identity fill of the whole table after reset
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == AW'(MAX_ROWS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (in_ch.data.func == FUNC_START)
                    begin
                        cursor_next = 11'd0;
                        gen_next    = (in_ch.data.seed != 32'd0) ? in_ch.data.seed : 32'd1;
                        ptr_next    = 11'd0;
                        if (rows == 11'd0)
                            state_next = ST_CNT_START;
                        else
                            state_next = ST_FILL;
                    end
                    else if (cursor_reg >= rows)
                        state_next = ST_EXHAUST;
                    else
                    begin
                        end_next   = (batch_end > {1'b0, rows}) ? rows : batch_end[10:0];
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_FILL:
            begin
                mem_we   = 1'b1;
                ptr_next = ptr_reg + 11'd1;
                if (ptr_reg == rows - 11'd1)
                begin
                    i_next = rows - 11'd1;
                    if (shuffle_en_reg && rows > 11'd1)
                        state_next = ST_DRAW;
                    else
                        state_next = ST_CNT_START;
                end
            end
            ST_DRAW:
            begin
                // j = x mod (i+1) through the serial divider
                gen_next   = x_draw;
                div_start  = 1'b1;
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                if (div_done)
                begin
                    j_next     = div_rem[10:0];
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                // port A register doubles as the output row; wait until it is free
                if (!pend_reg)
                begin
                    ra_en      = 1'b1;
                    rb_en      = 1'b1;
                    state_next = ST_SWAP_A;
                end
            end
            ST_SWAP_A:
            begin
                mem_we     = 1'b1;
                mem_waddr  = AW'(i_reg);
                mem_wdata  = rb_q;
                state_next = ST_SWAP_B;
            end
            ST_SWAP_B:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(j_reg);
                mem_wdata = ra_q;
                i_next    = i_reg - 11'd1;
                if (i_reg == 11'd1)
                    state_next = ST_CNT_START;
                else
                    state_next = ST_DRAW;
            end
            ST_CNT_START:
            begin
                // ceil(rows / batch)
                div_start    = 1'b1;
                div_dividend = 32'(rows) + 32'(batch) - 32'd1;
                div_divisor  = 12'(batch);
                state_next   = ST_CNT_WAIT;
            end
            ST_CNT_WAIT:
            begin
                if (div_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                // quotient holds in the divider; count loads with the item
                if (out_free)
                begin
                    pend_next  = 1'b1;
                    kind_next  = KIND_DONE;
                    last_next  = 1'b1;
                    count_next = div_quo[10:0];
                    state_next = ST_IDLE;
                end
            end
            ST_EXHAUST:
            begin
                if (out_free)
                begin
                    pend_next  = 1'b1;
                    kind_next  = KIND_EXHAUSTED;
                    last_next  = 1'b1;
                    count_next = 11'd0;
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                // one table read per free output slot
                ra = AW'(cursor_reg);
                if (out_free)
                begin
                    ra_en       = 1'b1;
                    pend_next   = 1'b1;
                    kind_next   = KIND_ROW;
                    count_next  = 11'd0;
                    last_next   = (cursor_reg + 11'd1 == end_reg);
                    cursor_next = cursor_reg + 11'd1;
                    if (cursor_reg + 11'd1 == end_reg)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            cursor_reg <= 11'd0;
            gen_reg    <= 32'd1;
            pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            cursor_reg <= cursor_next;
            gen_reg    <= gen_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        end_reg   <= end_next;
        kind_reg  <= kind_next;
        last_reg  <= last_next;
        count_reg <= count_next;
    end

    assign ra_wide = 32'(ra_q);

    assign out_ch.valid            = pend_reg;
    assign out_ch.data.kind        = kind_reg;
    assign out_ch.data.row_index   = (kind_reg == KIND_ROW) ? ra_wide[9:0] : 10'd0;
    assign out_ch.data.batch_count = count_reg;
    assign out_ch.data.last        = last_reg;
endmodule
